// ===== rtl/ida_pkg.sv =====
`timescale 1ns / 1ps
// Package for the entry ID allocator: sizes, operation and status codes,
// sequencer state type. No dependencies.
package ida_pkg;

   localparam int CAPACITY = 1024;
   localparam int ID_W     = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE         = 2'd0,
      STATUS_ALREADY_FREE = 2'd1,
      STATUS_FULL         = 2'd2,
      STATUS_RANGE        = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

// ===== rtl/id_allocator_hole_stack.sv =====
`timescale 1ns / 1ps
// Entry ID allocator with a LIFO stack of freed holes.
// Depends on ida_pkg.
//
// Usage:
//   Request channel (req_valid / req_stall): req_func selects allocate or
//   free, req_entry_id names the entry to free. Response channel
//   (rsp_valid / rsp_stall): status, ID, used length and hole count after
//   the operation, one item per request, in order.
// Timing:
//   In the accept cycle the valid map and the top of the hole stack are
//   read from their synchronous memories; in the execute state the result
//   is formed, written back and loaded into the response register. A new
//   request is taken only once the last one has finished, because of this
//   read-then-write sequence on the single-port memories.
//   The response is registered and appears when the execute state finishes.
// Reset:
//   Synchronous, active high. Length and hole count go to zero. The memories
//   are not cleared: only values below the used length or the hole count
//   are ever used, and every one of those has been written since reset.
// Back pressure:
//   A stalled response holds; the finishing cycle waits until the response
//   register is free, and no new request is taken meanwhile.
module id_allocator_hole_stack (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  logic [ida_pkg::ID_W-1:0] req_entry_id,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [ida_pkg::ID_W-1:0] rsp_assigned_id,
   output logic [ida_pkg::LEN_W-1:0] rsp_used_length,
   output logic [ida_pkg::ID_W-1:0] rsp_holes_left
);

   ida_pkg::state_type state_ff, state_in;

   logic                      req_take;
   logic                      exec_go;

   logic                      func_ff;
   logic [ida_pkg::ID_W-1:0]  id_ff;
   logic [ida_pkg::LEN_W-1:0] length_ff, length_in;
   logic [ida_pkg::ID_W-1:0]  count_ff, count_in;

   logic                      valid_mem [ida_pkg::CAPACITY];
   logic [ida_pkg::ID_W-1:0]  hole_mem  [ida_pkg::CAPACITY];
   logic                      valid_rd_ff;
   logic [ida_pkg::ID_W-1:0]  hole_rd_ff;

   logic                      vwr_en;
   logic [ida_pkg::ID_W-1:0]  vwr_addr;
   logic                      vwr_data;
   logic                      hwr_en;

   ida_pkg::status_type       res_status;
   logic [ida_pkg::ID_W-1:0]  res_id;

   logic                      rsp_valid_ff;
   ida_pkg::status_type       rsp_status_ff;
   logic [ida_pkg::ID_W-1:0]  rsp_id_ff;
   logic [ida_pkg::LEN_W-1:0] rsp_length_ff;
   logic [ida_pkg::ID_W-1:0]  rsp_holes_ff;

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ida_pkg::ST_IDLE: if (req_valid) state_in = ida_pkg::ST_EXEC;
         ida_pkg::ST_EXEC: if (exec_go)   state_in = ida_pkg::ST_IDLE;
         default:          state_in = ida_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      exec_go   = 1'b0;
      unique case (state_ff)
         ida_pkg::ST_IDLE: req_stall = 1'b0;
         ida_pkg::ST_EXEC: exec_go   = !rsp_valid_ff || !rsp_stall;
         default:          req_stall = 1'b1;
      endcase
   end

   assign req_take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ida_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---- request capture ----
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= req_func;
         id_ff   <= req_entry_id;
      end
   end

   // ---- memories: read on accept, write when finishing ----
   always_ff @(posedge clock) begin
      if (req_take) begin
         valid_rd_ff <= valid_mem[req_entry_id];
      end
      if (vwr_en) begin
         valid_mem[vwr_addr] <= vwr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         // top of stack; a wrapped address with no holes is never used
         hole_rd_ff <= hole_mem[count_ff - ida_pkg::ID_W'(1)];
      end
      if (hwr_en) begin
         hole_mem[count_ff] <= id_ff;
      end
   end

   // ---- operation ----
   always_comb begin
      length_in  = length_ff;
      count_in   = count_ff;
      vwr_en     = 1'b0;
      vwr_addr   = id_ff;
      vwr_data   = 1'b0;
      hwr_en     = 1'b0;
      res_status = ida_pkg::STATUS_DONE;
      res_id     = id_ff;
      if (func_ff == ida_pkg::FUNC_ALLOC) begin
         priority if (count_ff != '0) begin
            // reuse the most recent hole
            count_in = count_ff - ida_pkg::ID_W'(1);
            res_id   = hole_rd_ff;
            vwr_en   = exec_go;
            vwr_addr = hole_rd_ff;
            vwr_data = 1'b1;
         end else if (length_ff < ida_pkg::LEN_W'(ida_pkg::CAPACITY)) begin
            // append at the end of the table
            length_in = length_ff + ida_pkg::LEN_W'(1);
            res_id    = length_ff[ida_pkg::ID_W-1:0];
            vwr_en    = exec_go;
            vwr_addr  = length_ff[ida_pkg::ID_W-1:0];
            vwr_data  = 1'b1;
         end else begin
            res_status = ida_pkg::STATUS_FULL;
            res_id     = '0;
         end
      end else begin
         priority if (ida_pkg::LEN_W'(id_ff) >= length_ff) begin
            res_status = ida_pkg::STATUS_RANGE;
         end else if (!valid_rd_ff) begin
            res_status = ida_pkg::STATUS_ALREADY_FREE;
         end else begin
            vwr_en   = exec_go;
            vwr_data = 1'b0;
            if (ida_pkg::LEN_W'(id_ff) + ida_pkg::LEN_W'(1) == length_ff) begin
               // last entry: shrink the table
               length_in = length_ff - ida_pkg::LEN_W'(1);
            end else begin
               // hole count stays below capacity: holes lie under the last entry
               hwr_en   = exec_go;
               count_in = count_ff + ida_pkg::ID_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         count_ff  <= '0;
      end else if (exec_go) begin
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

   // ---- response register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_status_ff <= res_status;
         rsp_id_ff     <= res_id;
         rsp_length_ff <= length_in;
         rsp_holes_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_assigned_id = rsp_id_ff;
   assign rsp_used_length = rsp_length_ff;
   assign rsp_holes_left  = rsp_holes_ff;

endmodule

// ===== rtl/ida_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the entry ID allocator, bound to the top level.
// Depends on ida_pkg and id_allocator_hole_stack.
module ida_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      req_func,
   input logic [ida_pkg::ID_W-1:0]  req_entry_id,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [1:0]                rsp_status,
   input logic [ida_pkg::ID_W-1:0]  rsp_assigned_id,
   input logic [ida_pkg::LEN_W-1:0] rsp_used_length,
   input logic [ida_pkg::ID_W-1:0]  rsp_holes_left
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_assigned_id) && $stable(rsp_used_length)
         && $stable(rsp_holes_left))
      else $error("stalled response changed");

   // one request in flight: stall the cycle after an accepted item
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   a_full_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ida_pkg::STATUS_FULL |-> rsp_assigned_id == '0)
      else $error("full response with non-zero id");

   a_range_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ida_pkg::STATUS_RANGE
         |-> ida_pkg::LEN_W'(rsp_assigned_id) >= rsp_used_length)
      else $error("out-of-range response for an id inside the table");

   a_holes_in_table: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ida_pkg::LEN_W'(rsp_holes_left) <= rsp_used_length)
      else $error("more holes than table entries");

endmodule

bind id_allocator_hole_stack ida_checker u_ida_checker (.*);
